[rtl/dslr_pkg.sv]
// Shared types, register indexes and the speed clamp for the drive slew-rate limiter.
// No dependencies; used by dslr_side and drive_slew_rate_limiter.
`default_nettype none

package dslr_pkg;

  // Side and motor speed, -127..127 in use
  typedef logic signed [7:0] speed_t;

  // Saturation and deadband limits, shared by every clamp
  typedef struct packed {
    logic [6:0] speed_limit;
    logic [6:0] deadband;
  } lim_t;

  // Configuration register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_SPEED_LIMIT  = 3'd0,
    REG_DEADBAND     = 3'd1,
    REG_CHANGE_BAND  = 3'd2,
    REG_LINEAR_STEP  = 3'd3,
    REG_TURN_STEP    = 3'd4,
    REG_MOTOR_INVERT = 3'd5
  } reg_idx_t;

  // Saturate to +-speed limit first, then force small magnitudes to zero
  function automatic speed_t clamp_speed(input speed_t x, input lim_t lim);
    logic [7:0] mag;
    speed_t     lim_pos;
    mag     = x[7] ? 8'(-x) : 8'(x);
    lim_pos = speed_t'({1'b0, lim.speed_limit});
    if (mag > {1'b0, lim.speed_limit}) begin
      return x[7] ? -lim_pos : lim_pos;
    end else if (mag < {1'b0, lim.deadband}) begin
      return '0;
    end
    return x;
  endfunction

  // True when both values have the same three-way sign
  function automatic logic same_sign(input speed_t a, input speed_t b);
    return (a[7] == b[7]) && ((a == '0) == (b == '0));
  endfunction

endpackage

`default_nettype wire

[rtl/dslr_side.sv]
// One side's ramp: steps the old speed toward the command or takes the command.
// Depends on dslr_pkg (speed_t, lim_t, clamp_speed, same_sign).
`default_nettype none

module dslr_side (
  input  dslr_pkg::speed_t old_spd,
  input  dslr_pkg::speed_t cmd_spd,
  input  logic [6:0]       step,
  input  dslr_pkg::lim_t   lim,
  output dslr_pkg::speed_t new_spd
);
  import dslr_pkg::*;

  logic              ramp_en;
  logic [7:0]        cmd_mag;
  logic signed [9:0] old_ext;
  logic signed [9:0] step_ext;
  logic signed [9:0] max_ext;
  logic signed [9:0] up_val;
  logic signed [9:0] dn_val;
  speed_t            ramp_val;

  // Ramp only when the command clears the deadband and keeps the old sign
  assign cmd_mag = cmd_spd[7] ? 8'(-cmd_spd) : 8'(cmd_spd);
  assign ramp_en = (cmd_mag > {1'b0, lim.deadband}) && same_sign(cmd_spd, old_spd);

  assign old_ext  = 10'(old_spd);
  assign step_ext = signed'({3'b000, step});
  assign max_ext  = signed'({3'b000, lim.speed_limit});
  assign up_val   = old_ext + step_ext;
  assign dn_val   = old_ext - step_ext;

  // One step toward the command, saturated at +-speed limit
  always_comb begin
    if (!ramp_en) begin
      ramp_val = cmd_spd;
    end else if (cmd_spd > old_spd) begin
      ramp_val = (up_val > max_ext) ? speed_t'(max_ext[7:0]) : speed_t'(up_val[7:0]);
    end else if (cmd_spd < old_spd) begin
      ramp_val = (dn_val < -max_ext) ? speed_t'(8'(-max_ext)) : speed_t'(dn_val[7:0]);
    end else begin
      ramp_val = old_spd;
    end
  end

  assign new_spd = clamp_speed(ramp_val, lim);

endmodule

`default_nettype wire

[rtl/drive_slew_rate_limiter.sv]
// Drive slew-rate limiter: top level with config registers, pipeline and side state.
// Depends on dslr_pkg and dslr_side.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one drive word per control tick:
//   left/right command, turn flag and quad flag. Result channel
//   (out_valid/out_ready) returns one word per input word: applied side speeds,
//   four motor drive values and a flag telling whether the motors were updated.
//   Path: a word accepted at a clock edge is registered in the input stage,
//   processed combinationally from there and loaded into the result register
//   when that register can advance, which drives the result port.
//   Throughput: one word per cycle unless stalled; the side speed state is
//   updated along with the result register, so consecutive words chain directly.
//   Stall: when out_ready is low the result register holds its word, the input
//   stage still takes one more word, and in_ready drops only when both are full.
//   Reset (rst_n low, synchronous) empties both stages, clears the side speeds
//   and loads the register defaults: speed limit 127, deadband 15, change_band 10,
//   linear_step 10, turn_step 20, motor_invert 0.
//   Config: APB-style, registers at byte addresses 0x00..0x14, write only while
//   no word is in flight.
`default_nettype none

module drive_slew_rate_limiter #(
  parameter int COMMAND_BITS = 9
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [COMMAND_BITS-1:0] in_left_cmd,
  input  logic signed [COMMAND_BITS-1:0] in_right_cmd,
  input  logic                           in_turn_mode,
  input  logic                           in_quad_mode,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output dslr_pkg::speed_t               out_left_speed,
  output dslr_pkg::speed_t               out_right_speed,
  output dslr_pkg::speed_t               out_front_left,
  output dslr_pkg::speed_t               out_front_right,
  output dslr_pkg::speed_t               out_rear_left,
  output dslr_pkg::speed_t               out_rear_right,
  output logic                           out_motors_written,
  // configuration port
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [4:0]                     cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import dslr_pkg::*;

  // ---------------------------------------------------------------- config regs
  logic [6:0] speed_limit_r;
  logic [6:0] deadband_r;
  logic [7:0] change_band_r;
  logic [6:0] linear_step_r;
  logic [7:0] turn_step_r;
  logic [3:0] motor_invert_r;
  logic       cfg_wr;
  reg_idx_t   cfg_idx;
  lim_t       lim;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);
  assign lim        = '{speed_limit: speed_limit_r, deadband: deadband_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_limit_r  <= 7'd127;
      deadband_r     <= 7'd15;
      change_band_r  <= 8'd10;
      linear_step_r  <= 7'd10;
      turn_step_r    <= 8'd20;
      motor_invert_r <= 4'd0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SPEED_LIMIT:  speed_limit_r  <= cfg_pwdata[6:0];
        REG_DEADBAND:     deadband_r     <= cfg_pwdata[6:0];
        REG_CHANGE_BAND:  change_band_r  <= cfg_pwdata[7:0];
        REG_LINEAR_STEP:  linear_step_r  <= cfg_pwdata[6:0];
        REG_TURN_STEP:    turn_step_r    <= cfg_pwdata[7:0];
        REG_MOTOR_INVERT: motor_invert_r <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (cfg_idx)
      REG_SPEED_LIMIT:  cfg_prdata = {25'd0, speed_limit_r};
      REG_DEADBAND:     cfg_prdata = {25'd0, deadband_r};
      REG_CHANGE_BAND:  cfg_prdata = {24'd0, change_band_r};
      REG_LINEAR_STEP:  cfg_prdata = {25'd0, linear_step_r};
      REG_TURN_STEP:    cfg_prdata = {24'd0, turn_step_r};
      REG_MOTOR_INVERT: cfg_prdata = {28'd0, motor_invert_r};
      default:          cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- pipeline control
  logic                           s1_valid_r;
  logic signed [COMMAND_BITS-1:0] s1_left_r;
  logic signed [COMMAND_BITS-1:0] s1_right_r;
  logic                           s1_turn_r;
  logic                           s1_quad_r;
  logic                           out_valid_r;
  logic                           advance;
  logic                           in_acc;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // input stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_left_r  <= in_left_cmd;
      s1_right_r <= in_right_cmd;
      s1_turn_r  <= in_turn_mode;
      s1_quad_r  <= in_quad_mode;
    end
  end

  // ---------------------------------------------------------------- command clamp
  function automatic speed_t clamp_cmd(input logic signed [COMMAND_BITS-1:0] x,
                                       input lim_t l);
    logic [COMMAND_BITS-1:0] mag;
    speed_t                  lim_pos;
    mag     = x[COMMAND_BITS-1] ? COMMAND_BITS'(-x) : COMMAND_BITS'(x);
    lim_pos = speed_t'({1'b0, l.speed_limit});
    if (mag > COMMAND_BITS'(l.speed_limit)) begin
      return x[COMMAND_BITS-1] ? -lim_pos : lim_pos;
    end else if (mag < COMMAND_BITS'(l.deadband)) begin
      return '0;
    end
    return speed_t'(x[7:0]);
  endfunction

  // ---------------------------------------------------------------- side update
  speed_t last_left_r;
  speed_t last_right_r;
  speed_t old_l;
  speed_t old_r;
  speed_t cmd_l;
  speed_t cmd_r;
  speed_t ramp_l;
  speed_t ramp_r;
  logic   turn_eff;
  logic [6:0] step;
  logic signed [8:0] diff_l;
  logic signed [8:0] diff_r;
  logic [8:0] adiff_l;
  logic [8:0] adiff_r;
  logic   hold;

  assign old_l = clamp_speed(last_left_r, lim);
  assign old_r = clamp_speed(last_right_r, lim);
  assign cmd_l = clamp_cmd(s1_left_r, lim);
  assign cmd_r = clamp_cmd(s1_right_r, lim);

  // quad drive with unequal sides is not a point turn
  assign turn_eff = s1_turn_r && !(s1_quad_r && (cmd_l != cmd_r));
  assign step     = turn_eff ? turn_step_r[7:1] : linear_step_r;

  // hold when both sides keep their sign and move within the change band
  assign diff_l  = 9'(cmd_l) - 9'(old_l);
  assign diff_r  = 9'(cmd_r) - 9'(old_r);
  assign adiff_l = diff_l[8] ? 9'(-diff_l) : 9'(diff_l);
  assign adiff_r = diff_r[8] ? 9'(-diff_r) : 9'(diff_r);
  assign hold    = same_sign(cmd_l, old_l) && same_sign(cmd_r, old_r) &&
                   (adiff_l <= {1'b0, change_band_r}) &&
                   (adiff_r <= {1'b0, change_band_r});

  dslr_side u_side_l (
    .old_spd (old_l),
    .cmd_spd (cmd_l),
    .step    (step),
    .lim     (lim),
    .new_spd (ramp_l)
  );

  dslr_side u_side_r (
    .old_spd (old_r),
    .cmd_spd (cmd_r),
    .step    (step),
    .lim     (lim),
    .new_spd (ramp_r)
  );

  // ---------------------------------------------------------------- motor mapping
  speed_t new_l;
  speed_t new_r;
  speed_t rl_src;
  speed_t rr_src;
  speed_t fl_nxt;
  speed_t fr_nxt;
  speed_t rl_nxt;
  speed_t rr_nxt;

  assign new_l  = hold ? old_l : ramp_l;
  assign new_r  = hold ? old_r : ramp_r;
  assign rl_src = s1_quad_r ? ramp_r : ramp_l;
  assign rr_src = s1_quad_r ? ramp_l : ramp_r;
  assign fl_nxt = hold ? '0 : (motor_invert_r[0] ? -ramp_l : ramp_l);
  assign fr_nxt = hold ? '0 : (motor_invert_r[1] ? -ramp_r : ramp_r);
  assign rl_nxt = hold ? '0 : (motor_invert_r[2] ? -rl_src : rl_src);
  assign rr_nxt = hold ? '0 : (motor_invert_r[3] ? -rr_src : rr_src);

  // side speed state follows each word as it enters the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_left_r  <= '0;
      last_right_r <= '0;
    end else if (advance && s1_valid_r) begin
      last_left_r  <= new_l;
      last_right_r <= new_r;
    end
  end

  // ---------------------------------------------------------------- result register
  speed_t left_speed_r;
  speed_t right_speed_r;
  speed_t front_left_r;
  speed_t front_right_r;
  speed_t rear_left_r;
  speed_t rear_right_r;
  logic   written_r;

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      left_speed_r  <= new_l;
      right_speed_r <= new_r;
      front_left_r  <= fl_nxt;
      front_right_r <= fr_nxt;
      rear_left_r   <= rl_nxt;
      rear_right_r  <= rr_nxt;
      written_r     <= !hold;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_left_speed     = left_speed_r;
  assign out_right_speed    = right_speed_r;
  assign out_front_left     = front_left_r;
  assign out_front_right    = front_right_r;
  assign out_rear_left      = rear_left_r;
  assign out_rear_right     = rear_right_r;
  assign out_motors_written = written_r;

endmodule

`default_nettype wire

[test/tb_drive_slew_rate_limiter.sv]
// Testbench for drive_slew_rate_limiter: directed and random drive words, with an internal
// predictor of the side ramp, hold band and motor mapping, checked word by word.
// Depends on dslr_pkg and the drive_slew_rate_limiter RTL.
`timescale 1ns / 100ps

module tb_drive_slew_rate_limiter;

  localparam int CMD_W      = 9;
  localparam int LIMIT      = 200000;
  localparam int LIMIT_SLOP = 4;

  typedef struct packed {
    dslr_pkg::speed_t left_speed;
    dslr_pkg::speed_t right_speed;
    dslr_pkg::speed_t front_left;
    dslr_pkg::speed_t front_right;
    dslr_pkg::speed_t rear_left;
    dslr_pkg::speed_t rear_right;
    logic             motors_written;
  } drive_result_t;

  // DUT ports, all inputs known from time zero
  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [CMD_W-1:0] in_left_cmd = '0;
  logic signed [CMD_W-1:0] in_right_cmd = '0;
  logic                    in_turn_mode = 1'b0;
  logic                    in_quad_mode = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  dslr_pkg::speed_t        out_left_speed;
  dslr_pkg::speed_t        out_right_speed;
  dslr_pkg::speed_t        out_front_left;
  dslr_pkg::speed_t        out_front_right;
  dslr_pkg::speed_t        out_rear_left;
  dslr_pkg::speed_t        out_rear_right;
  logic                    out_motors_written;
  logic                    cfg_psel = 1'b0;
  logic                    cfg_penable = 1'b0;
  logic                    cfg_pwrite = 1'b0;
  logic [4:0]              cfg_paddr = '0;
  logic [31:0]             cfg_pwdata = '0;
  logic [31:0]             cfg_prdata;
  logic                    cfg_pready;

  // Predictor copy of the registers and the side state
  int         cfg_max  = 127;
  int         cfg_dead = 15;
  int         cfg_band = 10;
  int         cfg_lin  = 10;
  int         cfg_turn = 20;
  logic [3:0] cfg_inv  = 4'h0;
  int         applied_left  = 0;
  int         applied_right = 0;

  drive_result_t expected_drive_q[$];
  int            mismatch_count = 0;
  int            cycle_count = 0;
  bit            steady = 1'b0;

  drive_slew_rate_limiter #(.COMMAND_BITS(CMD_W)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_left_cmd(in_left_cmd), .in_right_cmd(in_right_cmd),
    .in_turn_mode(in_turn_mode), .in_quad_mode(in_quad_mode),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_left_speed(out_left_speed), .out_right_speed(out_right_speed),
    .out_front_left(out_front_left), .out_front_right(out_front_right),
    .out_rear_left(out_rear_left), .out_rear_right(out_rear_right),
    .out_motors_written(out_motors_written),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 8);
  end

  // ---------------------------------------------------------------- predictor
  function automatic int sgn(int x);
    return x > 0 ? 1 : (x < 0 ? -1 : 0);
  endfunction

  function automatic int absv(int x);
    return x < 0 ? -x : x;
  endfunction

  // Saturate first, then deadband
  function automatic int clamp_side(int x);
    if (absv(x) > cfg_max) return x < 0 ? -cfg_max : cfg_max;
    if (absv(x) < cfg_dead) return 0;
    return x;
  endfunction

  // One step toward cmd, or cmd itself when outside the ramp condition
  function automatic int ramp_side(int prev, int cmd, int step);
    if (!(absv(cmd) > cfg_dead && sgn(cmd) == sgn(prev))) return cmd;
    if (cmd > prev) return (prev + step > cfg_max) ? cfg_max : prev + step;
    if (cmd < prev) return (prev - step < -cfg_max) ? -cfg_max : prev - step;
    return prev;
  endfunction

  function automatic dslr_pkg::speed_t motor_drive(int v, logic [1:0] idx);
    int r;
    r = cfg_inv[idx] ? -v : v;
    return dslr_pkg::speed_t'(r);
  endfunction

  function automatic drive_result_t slew_predict(int lc, int rc, bit turn, bit quad);
    drive_result_t r;
    int            ol, orr, nl, nr, step;
    r   = '0;
    ol  = clamp_side(applied_left);
    orr = clamp_side(applied_right);
    nl  = clamp_side(lc);
    nr  = clamp_side(rc);
    // unequal sides in quad mode cancel the turn
    if (quad && nl != nr) turn = 1'b0;
    if (sgn(nl) == sgn(ol) && sgn(nr) == sgn(orr) &&
        absv(nl - ol) <= cfg_band && absv(nr - orr) <= cfg_band) begin
      nl = ol;
      nr = orr;
    end else begin
      step             = turn ? cfg_turn / 2 : cfg_lin;
      nl               = clamp_side(ramp_side(ol, nl, step));
      nr               = clamp_side(ramp_side(orr, nr, step));
      r.motors_written = 1'b1;
      r.front_left     = motor_drive(nl, 2'd0);
      r.front_right    = motor_drive(nr, 2'd1);
      r.rear_left      = motor_drive(quad ? nr : nl, 2'd2);
      r.rear_right     = motor_drive(quad ? nl : nr, 2'd3);
    end
    applied_left  = nl;
    applied_right = nr;
    r.left_speed  = dslr_pkg::speed_t'(nl);
    r.right_speed = dslr_pkg::speed_t'(nr);
    return r;
  endfunction

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    drive_result_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_left_speed, out_right_speed, out_front_left, out_front_right,
              out_rear_left, out_rear_right, out_motors_written};
      if (expected_drive_q.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10)
          $display("unexpected result word: L=%0d R=%0d", got.left_speed, got.right_speed);
      end else begin
        want = expected_drive_q.pop_front();
        if (got.left_speed !== want.left_speed || got.right_speed !== want.right_speed ||
            got.front_left !== want.front_left || got.front_right !== want.front_right ||
            got.rear_left !== want.rear_left || got.rear_right !== want.rear_right ||
            got.motors_written !== want.motors_written) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display({"mismatch exp L=%0d R=%0d FL=%0d FR=%0d RL=%0d RR=%0d W=%0b",
                      " got L=%0d R=%0d FL=%0d FR=%0d RL=%0d RR=%0d W=%0b"},
                     want.left_speed, want.right_speed, want.front_left, want.front_right,
                     want.rear_left, want.rear_right, want.motors_written,
                     got.left_speed, got.right_speed, got.front_left, got.front_right,
                     got.rear_left, got.rear_right, got.motors_written);
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  // Send one drive word; returns right after the accepting edge
  task automatic send_word(int lc, int rc, int turn, int quad);
    logic signed [CMD_W-1:0] lw;
    logic signed [CMD_W-1:0] rw;
    lw = CMD_W'(lc);
    rw = CMD_W'(rc);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_left_cmd  <= lw;
    in_right_cmd <= rw;
    in_turn_mode <= turn[0];
    in_quad_mode <= quad[0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_drive_q.push_back(slew_predict(int'(lw), int'(rw), turn[0], quad[0]));
  endtask

  // Drop valid and wait until every expected word is back, plus a LIMIT_SLOP margin
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_drive_q.size() != 0) @(posedge clk);
    repeat (LIMIT_SLOP) @(posedge clk);
  endtask

  task automatic set_reg(dslr_pkg::reg_idx_t idx, int val);
    wait_drained();
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= 32'(val);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      dslr_pkg::REG_SPEED_LIMIT:  cfg_max  = val & 8'h7F;
      dslr_pkg::REG_DEADBAND:     cfg_dead = val & 8'h7F;
      dslr_pkg::REG_CHANGE_BAND:  cfg_band = val & 8'hFF;
      dslr_pkg::REG_LINEAR_STEP:  cfg_lin  = val & 8'h7F;
      dslr_pkg::REG_TURN_STEP:    cfg_turn = val & 8'hFF;
      dslr_pkg::REG_MOTOR_INVERT: cfg_inv  = 4'(val);
      default: ;
    endcase
  endtask

  task automatic set_all(int mx, int db, int cb, int ls, int ts, int inv);
    set_reg(dslr_pkg::REG_SPEED_LIMIT, mx);
    set_reg(dslr_pkg::REG_DEADBAND, db);
    set_reg(dslr_pkg::REG_CHANGE_BAND, cb);
    set_reg(dslr_pkg::REG_LINEAR_STEP, ls);
    set_reg(dslr_pkg::REG_TURN_STEP, ts);
    set_reg(dslr_pkg::REG_MOTOR_INVERT, inv);
  endtask

  // ---------------------------------------------------------------- random helpers
  function automatic int pick_range(int lo, int hi);
    case ($urandom_range(0, 5))
      0:       return lo;
      1:       return hi;
      default: return lo + int'($urandom_range(0, hi - lo));
    endcase
  endfunction

  // Commands biased toward the full-scale, saturation and deadband edges
  function automatic int pick_cmd();
    int v, s;
    s = $urandom_range(0, 1) ? -1 : 1;
    case ($urandom_range(0, 6))
      0:       v = 255;
      1:       v = cfg_max + int'($urandom_range(0, 4)) - 2;
      2:       v = cfg_dead + int'($urandom_range(0, 4)) - 2;
      3:       v = 0;
      default: v = int'($urandom_range(0, 255));
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return s * v;
  endfunction

  task automatic set_random_config();
    set_all(pick_range(1, 127), pick_range(0, 127), pick_range(0, 255),
            pick_range(1, 127), pick_range(0, 254), int'($urandom_range(0, 15)));
  endtask

  // Mostly held targets repeated so the ramps step toward them, plus jitter and noise
  task automatic run_random_words(int count);
    int sent, kind, tl, tr, reps;
    int turn, quad;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 9);
      turn = int'($urandom_range(0, 1));
      quad = int'($urandom_range(0, 1));
      if (kind < 7) begin
        tl   = pick_cmd();
        tr   = (quad != 0 && $urandom_range(0, 1) != 0) ? tl : pick_cmd();
        reps = $urandom_range(2, 12);
        repeat (reps) send_word(tl, tr, turn, quad);
        sent += reps;
      end else if (kind == 7) begin
        // small moves around the applied speed exercise the hold band
        send_word(applied_left + int'($urandom_range(0, 8)) - 4,
                  applied_right + int'($urandom_range(0, 8)) - 4, turn, quad);
        sent++;
      end else begin
        send_word(int'($urandom_range(0, 510)) - 255, int'($urandom_range(0, 510)) - 255,
                  turn, quad);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------- tests
  // Register defaults after reset: hold, direct jump, ramps, turn and quad handling
  task automatic test_reset_defaults();
    send_word(0, 0, 0, 0);          // hold at rest
    send_word(255, 255, 0, 0);      // full forward, taken directly, saturated
    send_word(100, 100, 0, 0);      // ramp down by the linear step
    send_word(-255, -255, 0, 0);    // sign flip, direct
    send_word(5, -5, 0, 0);         // inside deadband
    send_word(40, -40, 1, 0);       // point turn start
    send_word(90, -90, 1, 0);       // turn ramp with half turn step
    send_word(90, -60, 1, 1);       // quad with unequal sides cancels turn
    send_word(70, 70, 1, 1);        // quad with equal sides keeps turn
    send_word(74, 66, 0, 1);        // within change band: hold
    set_reg(dslr_pkg::REG_MOTOR_INVERT, 15);
    send_word(-120, 120, 0, 1);     // every motor inverted, rear sides swapped
  endtask

  // Widest and narrowest register settings; deadband above the speed limit
  task automatic test_config_extremes();
    set_all(127, 0, 0, 127, 254, 5);
    send_word(255, -255, 0, 0);
    send_word(1, -1, 0, 0);
    send_word(127, -127, 1, 0);
    send_word(-2, 3, 1, 1);
    set_all(1, 127, 255, 1, 0, 10);
    send_word(-255, 255, 0, 0);
    send_word(255, -255, 1, 1);
    send_word(0, 0, 0, 0);
  endtask

  // Zero speed limit clamps everything; zero steps freeze ramped sides
  task automatic test_zero_limits();
    set_all(0, 15, 10, 10, 20, 0);
    send_word(255, -255, 0, 0);
    send_word(-100, 100, 1, 1);
    set_all(127, 10, 5, 0, 0, 3);
    send_word(50, -50, 0, 0);
    send_word(120, -120, 0, 0);
    send_word(120, -120, 1, 0);
  endtask

  task automatic test_random_settings();
    repeat (8) begin
      set_random_config();
      run_random_words(95);
    end
  endtask

  // Back-to-back words on both sides with no idling
  task automatic test_steady_stream();
    set_all(100, 8, 6, 12, 40, 9);
    wait_drained();
    steady = 1'b1;
    run_random_words(80);
    wait_drained();
    steady = 1'b0;
  endtask

  // Sender waits for the pipe to empty before every word
  task automatic test_drain_pause();
    set_random_config();
    repeat (30) begin
      send_word(pick_cmd(), pick_cmd(), int'($urandom_range(0, 1)),
                int'($urandom_range(0, 1)));
      wait_drained();
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_config_extremes();
    test_zero_limits();
    test_random_settings();
    test_steady_stream();
    test_drain_pause();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
